>>> sv/bpd_pkg.sv
// Shared constants, widths and helpers for the Bezier point distance core.
// No dependencies.
`default_nettype none

package bpd_pkg;

  localparam int unsigned SEGMENTS = 4;
  localparam int unsigned NSEG     = SEGMENTS + 1;
  localparam int unsigned NPTS     = SEGMENTS + 2;
  localparam int unsigned QBITS    = 16;
  localparam int unsigned LANE_LAT = QBITS + 7;
  localparam int unsigned GRP      = 4;
  localparam int unsigned NGRP     = (NSEG + GRP - 1) / GRP;
  localparam longint unsigned N3   = longint'(NSEG) * NSEG * NSEG;

  localparam int unsigned AW = 3;
  localparam int unsigned DW = 64;
  localparam logic [AW-1:0] ADDR_HIT_THRESHOLD = 3'd0;

  localparam logic [32:0] DIST_MAX  = 33'd8589672450;
  localparam logic [32:0] THR_RESET = 33'd3840;

  // Bernstein weight j of sample i in Q1.16, rounded half up
  function automatic logic [16:0] bpd_weight(input int unsigned i, input int unsigned j);
    longint unsigned a;
    longint unsigned num;
    int unsigned     k;
    a   = longint'(NSEG - i);
    num = 64'd65536;
    if (j == 1 || j == 2) num = num * 3;
    for (k = 0; k < 3; k++) begin
      num = (k < 3 - j) ? num * a : num * i;
    end
    return 17'((2 * num + N3) / (2 * N3));
  endfunction

endpackage

`default_nettype wire

>>> sv/bpd_sampler.sv
// Curve sampler: two stages, Bernstein sums then rounding and saturation.
// Depends on bpd_pkg.
`default_nettype none

module bpd_sampler import bpd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               valid_i,
  input  wire logic signed [15:0] px_i,
  input  wire logic signed [15:0] py_i,
  input  wire logic signed [15:0] cx_i [4],
  input  wire logic signed [15:0] cy_i [4],
  output logic                    valid_o,
  output logic signed [15:0]      px_o,
  output logic signed [15:0]      py_o,
  output logic signed [15:0]      ptx_o [NPTS],
  output logic signed [15:0]      pty_o [NPTS]
);

  logic               v1_q, v2_q;
  logic signed [35:0] accx_d [SEGMENTS];
  logic signed [35:0] accy_d [SEGMENTS];
  logic signed [35:0] accx_q [SEGMENTS];
  logic signed [35:0] accy_q [SEGMENTS];
  logic signed [15:0] px1_q, py1_q, x0_q, y0_q, x3_q, y3_q;
  logic signed [15:0] px2_q, py2_q;
  logic signed [15:0] ptx_d [NPTS];
  logic signed [15:0] pty_d [NPTS];
  logic signed [15:0] ptx_q [NPTS];
  logic signed [15:0] pty_q [NPTS];

  function automatic logic signed [15:0] sat_q4(input logic signed [35:0] acc);
    logic signed [35:0] sum;
    logic signed [19:0] q;
    sum = acc + 36'sd32768;
    q   = sum[35:16];
    if (q < -20'sd32768) return 16'sh8000;
    if (q > 20'sd32767) return 16'sh7fff;
    return q[15:0];
  endfunction

  always_comb begin
    for (int s = 0; s < SEGMENTS; s++) begin
      accx_d[s] = '0;
      accy_d[s] = '0;
      for (int j = 0; j < 4; j++) begin
        accx_d[s] = accx_d[s] + ($signed({1'b0, bpd_weight(s + 1, j)}) * cx_i[j]);
        accy_d[s] = accy_d[s] + ($signed({1'b0, bpd_weight(s + 1, j)}) * cy_i[j]);
      end
    end
  end

  always_comb begin
    ptx_d[0]      = x0_q;
    pty_d[0]      = y0_q;
    ptx_d[NPTS-1] = x3_q;
    pty_d[NPTS-1] = y3_q;
    for (int s = 0; s < SEGMENTS; s++) begin
      ptx_d[s+1] = sat_q4(accx_q[s]);
      pty_d[s+1] = sat_q4(accy_q[s]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      accx_q <= accx_d;
      accy_q <= accy_d;
      px1_q  <= px_i;
      py1_q  <= py_i;
      x0_q   <= cx_i[0];
      y0_q   <= cy_i[0];
      x3_q   <= cx_i[3];
      y3_q   <= cy_i[3];
      ptx_q  <= ptx_d;
      pty_q  <= pty_d;
      px2_q  <= px1_q;
      py2_q  <= py1_q;
    end
  end

  assign valid_o = v2_q;
  assign px_o    = px2_q;
  assign py_o    = py2_q;
  assign ptx_o   = ptx_q;
  assign pty_o   = pty_q;

endmodule

`default_nettype wire

>>> sv/bpd_lane.sv
// One polyline segment: projection, pipelined restoring divide, rounded distance.
// Depends on bpd_pkg. Data registers only.
`default_nettype none

module bpd_lane import bpd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               adv_i,
  input  wire logic signed [15:0] px_i,
  input  wire logic signed [15:0] py_i,
  input  wire logic signed [15:0] ax_i,
  input  wire logic signed [15:0] ay_i,
  input  wire logic signed [15:0] bx_i,
  input  wire logic signed [15:0] by_i,
  output logic [32:0]             dist_o
);

  typedef struct packed {
    logic signed [16:0] tx;
    logic signed [16:0] ty;
    logic signed [16:0] dxa;
    logic signed [16:0] dya;
    logic [32:0]        zd;
    logic               pos;
    logic               ge;
    logic               zero;
  } seg_t;

  // L1: differences
  logic signed [16:0] tx1_q, ty1_q, dxa1_q, dya1_q, dxb1_q, dyb1_q;
  // L2: products
  logic signed [16:0] tx2_q, ty2_q, dxa2_q, dya2_q;
  logic [33:0]        txx_q, tyy_q, zxx_q, zyy_q;
  logic signed [33:0] mdx_q, mdy_q;
  // L3 + divider
  logic [33:0]        len2_d;
  logic signed [34:0] dot_d;
  seg_t               seg_d;
  seg_t               seg_q [QBITS+1];
  logic [33:0]        len_q [QBITS+1];
  logic [33:0]        rem_q [QBITS+1];
  logic [QBITS-1:0]   quo_q [QBITS+1];
  logic [33:0]        rem_d [QBITS];
  logic [QBITS-1:0]   quo_d [QBITS];
  // L4..L7
  logic [QBITS:0]     t_d;
  logic signed [35:0] ex_d, ey_d, ex_q, ey_q;
  logic [35:0]        magx_d, magy_d;
  logic [24:0]        d8x_q, d8y_q;
  logic [49:0]        sqx_q, sqy_q;
  logic [50:0]        s_d;
  logic [43:0]        r_d;
  logic [32:0]        zd4_q, zd5_q, zd6_q, dist_q;
  logic               z4_q, z5_q, z6_q;

  assign len2_d = txx_q + tyy_q;
  assign dot_d  = mdx_q + mdy_q;

  always_comb begin
    seg_d.tx   = tx2_q;
    seg_d.ty   = ty2_q;
    seg_d.dxa  = dxa2_q;
    seg_d.dya  = dya2_q;
    seg_d.zd   = 33'(zxx_q + zyy_q);
    seg_d.pos  = dot_d > 35'sd0;
    seg_d.ge   = dot_d >= $signed({1'b0, len2_d});
    seg_d.zero = len2_d == '0;
  end

  // one quotient bit per stage; dot < len2 holds for the used quotient
  always_comb begin
    for (int k = 0; k < QBITS; k++) begin
      logic [34:0] sub;
      sub = {rem_q[k], 1'b0} - {1'b0, len_q[k]};
      if (!sub[34]) begin
        rem_d[k] = sub[33:0];
        quo_d[k] = {quo_q[k][QBITS-2:0], 1'b1};
      end else begin
        rem_d[k] = {rem_q[k][32:0], 1'b0};
        quo_d[k] = {quo_q[k][QBITS-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (!seg_q[QBITS].pos)    t_d = '0;
    else if (seg_q[QBITS].ge) t_d = {1'b1, {QBITS{1'b0}}};
    else                      t_d = {1'b0, quo_q[QBITS]};
    ex_d = $signed({seg_q[QBITS].dxa, {QBITS{1'b0}}}) - (seg_q[QBITS].tx * $signed({1'b0, t_d}));
    ey_d = $signed({seg_q[QBITS].dya, {QBITS{1'b0}}}) - (seg_q[QBITS].ty * $signed({1'b0, t_d}));
    magx_d = ex_q[35] ? 36'(-ex_q) : 36'(ex_q);
    magy_d = ey_q[35] ? 36'(-ey_q) : 36'(ey_q);
    s_d = 51'(sqx_q) + 51'(sqy_q);
    r_d = 44'((52'(s_d) + 52'd128) >> 8);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tx1_q  <= 17'(bx_i) - 17'(ax_i);
      ty1_q  <= 17'(by_i) - 17'(ay_i);
      dxa1_q <= 17'(px_i) - 17'(ax_i);
      dya1_q <= 17'(py_i) - 17'(ay_i);
      dxb1_q <= 17'(px_i) - 17'(bx_i);
      dyb1_q <= 17'(py_i) - 17'(by_i);

      tx2_q  <= tx1_q;
      ty2_q  <= ty1_q;
      dxa2_q <= dxa1_q;
      dya2_q <= dya1_q;
      txx_q  <= 34'(tx1_q * tx1_q);
      tyy_q  <= 34'(ty1_q * ty1_q);
      zxx_q  <= 34'(dxb1_q * dxb1_q);
      zyy_q  <= 34'(dyb1_q * dyb1_q);
      mdx_q  <= dxa1_q * tx1_q;
      mdy_q  <= dya1_q * ty1_q;

      seg_q[0] <= seg_d;
      len_q[0] <= len2_d;
      rem_q[0] <= dot_d[33:0];
      quo_q[0] <= '0;
      for (int k = 0; k < QBITS; k++) begin
        seg_q[k+1] <= seg_q[k];
        len_q[k+1] <= len_q[k];
        rem_q[k+1] <= rem_d[k];
        quo_q[k+1] <= quo_d[k];
      end

      ex_q  <= ex_d;
      ey_q  <= ey_d;
      zd4_q <= seg_q[QBITS].zd;
      z4_q  <= seg_q[QBITS].zero;

      d8x_q <= 25'((37'(magx_d) + 37'd2048) >> 12);
      d8y_q <= 25'((37'(magy_d) + 37'd2048) >> 12);
      zd5_q <= zd4_q;
      z5_q  <= z4_q;

      sqx_q <= d8x_q * d8x_q;
      sqy_q <= d8y_q * d8y_q;
      zd6_q <= zd5_q;
      z6_q  <= z5_q;

      if (z6_q)                       dist_q <= zd6_q;
      else if (r_d > 44'(DIST_MAX))   dist_q <= DIST_MAX;
      else                            dist_q <= r_d[32:0];
    end
  end

  assign dist_o = dist_q;

endmodule

`default_nettype wire

>>> sv/bpd_min.sv
// Two-stage minimum over segment distances and threshold compare.
// Depends on bpd_pkg.
`default_nettype none

module bpd_min import bpd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire logic        valid_i,
  input  wire logic [32:0] dist_i [NSEG],
  input  wire logic [32:0] thr_i,
  output logic             valid_o,
  output logic [32:0]      dist_o,
  output logic             hit_o
);

  logic        v1_q, v2_q;
  logic [32:0] gmin_d [NGRP];
  logic [32:0] gmin_q [NGRP];
  logic [32:0] best_d, best_q;
  logic        hit_q;

  // slots past the last segment repeat the last segment
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      gmin_d[g] = DIST_MAX;
      for (int j = 0; j < GRP; j++) begin
        if (dist_i[(g * GRP + j < NSEG) ? g * GRP + j : NSEG - 1] < gmin_d[g]) begin
          gmin_d[g] = dist_i[(g * GRP + j < NSEG) ? g * GRP + j : NSEG - 1];
        end
      end
    end
    best_d = DIST_MAX;
    for (int g = 0; g < NGRP; g++) begin
      if (gmin_q[g] < best_d) best_d = gmin_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      gmin_q <= gmin_d;
      best_q <= best_d;
      hit_q  <= best_d <= thr_i;
    end
  end

  assign valid_o = v2_q;
  assign dist_o  = best_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire

>>> sv/bezier_point_distance_core.sv
// Bezier point distance core, top level: config register, sampler, segment lanes, min.
// Depends on bpd_pkg, bpd_sampler, bpd_lane, bpd_min.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request: the query point and the
//   four control points of a cubic curve. Output channel (out_valid_o/out_ready_i)
//   returns the minimum squared distance to the sampled polyline and the hit flag.
//   hit_threshold sits at APB address 0 (64-bit data, low 33 bits used).
// Throughput: one request per cycle while the receiver takes results.
// Depth: set by the one-bit-per-stage divide of each segment lane.
// Stall: the whole pipeline holds when a result waits and out_ready_i is low;
//   in_ready_o then drops, nothing is lost or repeated. Bubbles hold their place
//   during a stall and move only while the output side advances.
// Reset: all valid bits clear, no result pending, hit_threshold returns to 3840.
`default_nettype none

module bezier_point_distance_core import bpd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [AW-1:0]      paddr,
  input  wire logic [DW-1:0]      pwdata,
  output logic [DW-1:0]           prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] point_x_i,
  input  wire logic signed [15:0] point_y_i,
  input  wire logic signed [15:0] start_x_i,
  input  wire logic signed [15:0] start_y_i,
  input  wire logic signed [15:0] ctrl1_x_i,
  input  wire logic signed [15:0] ctrl1_y_i,
  input  wire logic signed [15:0] ctrl2_x_i,
  input  wire logic signed [15:0] ctrl2_y_i,
  input  wire logic signed [15:0] end_x_i,
  input  wire logic signed [15:0] end_y_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [32:0]             squared_distance_o,
  output logic                    hit_o
);

  logic               adv;
  logic [32:0]        thr_q;
  logic signed [15:0] cx [4];
  logic signed [15:0] cy [4];
  logic               samp_v;
  logic signed [15:0] spx, spy;
  logic signed [15:0] ptx [NPTS];
  logic signed [15:0] pty [NPTS];
  logic [LANE_LAT-1:0] lv_q;
  logic [32:0]        seg_dist [NSEG];

  assign adv        = out_ready_i | ~out_valid_o;
  assign in_ready_o = adv;
  assign pready     = 1'b1;
  assign prdata     = {{(DW-33){1'b0}}, thr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_HIT_THRESHOLD) begin
      thr_q <= pwdata[32:0];
    end
  end

  assign cx = '{start_x_i, ctrl1_x_i, ctrl2_x_i, end_x_i};
  assign cy = '{start_y_i, ctrl1_y_i, ctrl2_y_i, end_y_i};

  bpd_sampler u_samp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .px_i    (point_x_i),
    .py_i    (point_y_i),
    .cx_i    (cx),
    .cy_i    (cy),
    .valid_o (samp_v),
    .px_o    (spx),
    .py_o    (spy),
    .ptx_o   (ptx),
    .pty_o   (pty)
  );

  for (genvar k = 0; k < NSEG; k++) begin : g_lane
    bpd_lane u_lane (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .px_i   (spx),
      .py_i   (spy),
      .ax_i   (ptx[k]),
      .ay_i   (pty[k]),
      .bx_i   (ptx[k+1]),
      .by_i   (pty[k+1]),
      .dist_o (seg_dist[k])
    );
  end

  // valid bits alongside the lane data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q <= '0;
    end else if (adv) begin
      lv_q <= {lv_q[LANE_LAT-2:0], samp_v};
    end
  end

  bpd_min u_min (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (lv_q[LANE_LAT-1]),
    .dist_i  (seg_dist),
    .thr_i   (thr_q),
    .valid_o (out_valid_o),
    .dist_o  (squared_distance_o),
    .hit_o   (hit_o)
  );

endmodule

`default_nettype wire

>>> sv/bpd_checker.sv
// Port-level checks for bezier_point_distance_core, bound to the top level.
// Depends on bpd_pkg.
`default_nettype none

module bpd_checker import bpd_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               psel,
  input wire logic               penable,
  input wire logic               pwrite,
  input wire logic [AW-1:0]      paddr,
  input wire logic [DW-1:0]      pwdata,
  input wire logic [DW-1:0]      prdata,
  input wire logic               pready,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic signed [15:0] point_x_i,
  input wire logic signed [15:0] point_y_i,
  input wire logic signed [15:0] start_x_i,
  input wire logic signed [15:0] start_y_i,
  input wire logic signed [15:0] ctrl1_x_i,
  input wire logic signed [15:0] ctrl1_y_i,
  input wire logic signed [15:0] ctrl2_x_i,
  input wire logic signed [15:0] ctrl2_y_i,
  input wire logic signed [15:0] end_x_i,
  input wire logic signed [15:0] end_y_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [32:0]        squared_distance_o,
  input wire logic               hit_o
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(squared_distance_o) && $stable(hit_o))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (out_ready_i || !out_valid_o))
    else $error("request ready does not follow output side");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> squared_distance_o <= DIST_MAX)
    else $error("distance above range");

  a_zero_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && squared_distance_o == '0 |-> hit_o)
    else $error("zero distance without hit");

endmodule

bind bezier_point_distance_core bpd_checker u_bpd_checker (.*);

`default_nettype wire
